>>> sv/priority_queue_decrease_key_assert.svh
// Assertion macros for the priority queue block.
// Used by the top level only; expects clk and arst_n in the including scope.
`ifndef PRIORITY_QUEUE_DECREASE_KEY_ASSERT_SVH
`define PRIORITY_QUEUE_DECREASE_KEY_ASSERT_SVH
`ifndef SYNTHESIS
`define PQDK_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("priority queue check failed");
`define PQDK_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("priority queue check failed");
`else
`define PQDK_ASSERT(lbl, prop)
`define PQDK_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

>>> sv/pqdk_pkg.sv
// Shared codes for the priority queue: command, status and cell operation codes.
// No dependencies.
package pqdk_pkg;

	localparam logic [2:0] CMD_INSERT       = 3'd0;
	localparam logic [2:0] CMD_DELETE_MIN   = 3'd1;
	localparam logic [2:0] CMD_DECREASE_KEY = 3'd2;
	localparam logic [2:0] CMD_DELETE_ENTRY = 3'd3;
	localparam logic [2:0] CMD_FIND_MIN     = 3'd4;

	localparam logic [2:0] ST_OK           = 3'd0;
	localparam logic [2:0] ST_BAD_HANDLE   = 3'd1;
	localparam logic [2:0] ST_KEY_INCREASE = 3'd2;
	localparam logic [2:0] ST_EMPTY        = 3'd3;
	localparam logic [2:0] ST_FULL         = 3'd4;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE
	} cell_op_t;

endpackage

>>> sv/priority_queue_decrease_key.sv
// Top level of the bounded min-priority queue with handles and decrease-key.
// Depends on pqdk_pkg, pqdk_cell and priority_queue_decrease_key_assert.svh.
//
// Channel   Direction  Beat contents
// s_axis    in         tuser: cmd; tdata: entry_handle, key_value, payload
// m_axis    out        tuser: status; tdata: result_handle, result_key,
//                      result_payload, is_empty, entry_count
//
// Every command but decrease-key puts its result in the output register in the cycle
// after acceptance; decrease-key first pulls the entry out of the chain on
// acceptance and then, in the PLACE state, puts it back at its new place.
// The cell chain applies one shift per cycle.
// A new beat is accepted while the previous result is being taken in the same
// cycle; a stalled result or the PLACE state holds the input off. Reset empties the queue at once.
module priority_queue_decrease_key #(
	parameter int CAPACITY     = 64,
	parameter int KEY_BITS     = 32,
	parameter int PAYLOAD_BITS = 16,
	localparam int HW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	localparam int CW    = $clog2(CAPACITY + 1),
	localparam int IN_W  = ((HW + KEY_BITS + PAYLOAD_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((HW + KEY_BITS + PAYLOAD_BITS + 1 + CW + 7) / 8) * 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// tdata from bit 0 up: entry_handle, key_value, payload, zero padding
	input  logic [IN_W-1:0]     s_tdata,
	// tuser: cmd
	input  logic [2:0]          s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// tdata from bit 0 up: result_handle, result_key, result_payload, is_empty,
	// entry_count, zero padding
	output logic [OUT_W-1:0]    m_tdata,
	// tuser: status
	output logic [2:0]          m_tuser
);

	typedef enum logic {IDLE, PLACE} state_t;

	state_t                     state_q;
	logic                       out_valid_q;
	logic [2:0]                 out_status_q;
	logic [HW-1:0]              out_hnd_q;
	logic signed [KEY_BITS-1:0] out_key_q;
	logic [PAYLOAD_BITS-1:0]    out_pay_q;
	logic [CW-1:0]              count_q;
	logic [CAPACITY-1:0]        slot_q;
	logic signed [KEY_BITS-1:0] pend_key_q;
	logic [PAYLOAD_BITS-1:0]    pend_pay_q;
	logic [HW-1:0]              pend_hnd_q;

	// Input beat fields.
	logic [2:0]                 in_cmd;
	logic [HW-1:0]              in_hnd;
	logic signed [KEY_BITS-1:0] in_key;
	logic [PAYLOAD_BITS-1:0]    in_pay;
	logic                       in_fire;

	assign in_cmd = s_tuser;
	assign in_hnd = s_tdata[HW-1:0];
	assign in_key = $signed(s_tdata[HW+KEY_BITS-1:HW]);
	assign in_pay = s_tdata[HW+KEY_BITS+PAYLOAD_BITS-1:HW+KEY_BITS];

	assign s_tready = (state_q == IDLE) && (!out_valid_q || m_tready);
	assign in_fire  = s_tvalid && s_tready;

	// Chain wiring.
	pqdk_pkg::cell_op_t         cell_op;
	logic signed [KEY_BITS-1:0] new_key;
	logic [PAYLOAD_BITS-1:0]    new_pay;
	logic [HW-1:0]              new_hnd;
	logic                       rem_head;

	logic signed [KEY_BITS-1:0] c_key   [CAPACITY];
	logic [PAYLOAD_BITS-1:0]    c_pay   [CAPACITY];
	logic [HW-1:0]              c_hnd   [CAPACITY];
	logic [CAPACITY-1:0]        c_valid;
	logic [CAPACITY-1:0]        c_le;
	logic [CAPACITY-1:0]        c_match;
	logic [CAPACITY-1:0]        c_after;
	logic [CAPACITY-1:0]        c_inc;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [KEY_BITS-1:0] p_key, n_key;
		logic [PAYLOAD_BITS-1:0]    p_pay, n_pay;
		logic [HW-1:0]              p_hnd, n_hnd;
		logic                       p_valid, p_le, p_after, n_valid;

		if (i == 0) begin : g_head
			// The head sees a virtual neighbor in front that is valid and no larger than the new key.
			assign p_key   = '0;
			assign p_pay   = '0;
			assign p_hnd   = '0;
			assign p_valid = 1'b1;
			assign p_le    = 1'b1;
			assign p_after = rem_head;
		end else begin : g_body
			assign p_key   = c_key[i-1];
			assign p_pay   = c_pay[i-1];
			assign p_hnd   = c_hnd[i-1];
			assign p_valid = c_valid[i-1];
			assign p_le    = c_le[i-1];
			assign p_after = c_after[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign n_key   = '0;
			assign n_pay   = '0;
			assign n_hnd   = '0;
			assign n_valid = 1'b0;
		end else begin : g_link
			assign n_key   = c_key[i+1];
			assign n_pay   = c_pay[i+1];
			assign n_hnd   = c_hnd[i+1];
			assign n_valid = c_valid[i+1];
		end

		pqdk_cell #(
			.KEY_BITS    (KEY_BITS),
			.PAYLOAD_BITS(PAYLOAD_BITS),
			.HANDLE_BITS (HW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.op        (cell_op),
			.new_key   (new_key),
			.new_pay   (new_pay),
			.new_hnd   (new_hnd),
			.match_hnd (in_hnd),
			.prev_key  (p_key),
			.prev_pay  (p_pay),
			.prev_hnd  (p_hnd),
			.prev_valid(p_valid),
			.prev_le   (p_le),
			.prev_after(p_after),
			.next_key  (n_key),
			.next_pay  (n_pay),
			.next_hnd  (n_hnd),
			.next_valid(n_valid),
			.key       (c_key[i]),
			.pay       (c_pay[i]),
			.hnd       (c_hnd[i]),
			.valid     (c_valid[i]),
			.le        (c_le[i]),
			.match     (c_match[i]),
			.after     (c_after[i]),
			.inc       (c_inc[i])
		);
	end

	// Lowest free slot: isolate the lowest set bit of the free map, then encode it.
	logic [CAPACITY-1:0] free_map;
	logic [CAPACITY-1:0] free_onehot;
	logic [HW-1:0]       free_idx;

	assign free_map    = ~slot_q;
	assign free_onehot = free_map & (~free_map + {{(CAPACITY-1){1'b0}}, 1'b1});

	always_comb begin
		free_idx = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (free_onehot[i]) free_idx = free_idx | HW'(i);
		end
	end

	// Key and payload of the cell that holds the named handle (at most one does).
	logic signed [KEY_BITS-1:0] sel_key;
	logic [PAYLOAD_BITS-1:0]    sel_pay;

	always_comb begin
		sel_key = '0;
		sel_pay = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (c_match[i]) begin
				sel_key = sel_key | c_key[i];
				sel_pay = sel_pay | c_pay[i];
			end
		end
	end

	logic hnd_held;
	logic q_empty;
	logic q_full;

	assign hnd_held = ({1'b0, in_hnd} < (HW+1)'(CAPACITY)) && slot_q[in_hnd];
	assign q_empty  = (count_q == '0);
	assign q_full   = (count_q == CW'(CAPACITY));

	// Command decode and the next values of the queue state.
	logic                       ld_out;
	logic                       go_place;
	logic [2:0]                 nx_status;
	logic [HW-1:0]              nx_hnd;
	logic signed [KEY_BITS-1:0] nx_key;
	logic [PAYLOAD_BITS-1:0]    nx_pay;
	logic [CW-1:0]              nx_count;
	logic                       slot_set;
	logic                       slot_clr;
	logic [HW-1:0]              slot_idx;

	always_comb begin
		cell_op   = pqdk_pkg::CELL_HOLD;
		new_key   = in_key;
		new_pay   = in_pay;
		new_hnd   = free_idx;
		rem_head  = 1'b0;
		ld_out    = 1'b0;
		go_place  = 1'b0;
		nx_status = pqdk_pkg::ST_OK;
		nx_hnd    = '0;
		nx_key    = '0;
		nx_pay    = '0;
		nx_count  = count_q;
		slot_set  = 1'b0;
		slot_clr  = 1'b0;
		slot_idx  = in_hnd;
		unique case (state_q)
			IDLE: begin
				if (in_fire) begin
					ld_out = 1'b1;
					case (in_cmd)
						pqdk_pkg::CMD_INSERT: begin
							if (q_full) begin
								nx_status = pqdk_pkg::ST_FULL;
							end else begin
								cell_op  = pqdk_pkg::CELL_INSERT;
								slot_set = 1'b1;
								slot_idx = free_idx;
								nx_hnd   = free_idx;
								nx_key   = in_key;
								nx_pay   = in_pay;
								nx_count = count_q + 1'b1;
							end
						end
						pqdk_pkg::CMD_DELETE_MIN, pqdk_pkg::CMD_FIND_MIN: begin
							if (q_empty) begin
								nx_status = pqdk_pkg::ST_EMPTY;
							end else begin
								nx_hnd = c_hnd[0];
								nx_key = c_key[0];
								nx_pay = c_pay[0];
								if (in_cmd == pqdk_pkg::CMD_DELETE_MIN) begin
									cell_op  = pqdk_pkg::CELL_REMOVE;
									rem_head = 1'b1;
									slot_clr = 1'b1;
									slot_idx = c_hnd[0];
									nx_count = count_q - 1'b1;
								end
							end
						end
						pqdk_pkg::CMD_DECREASE_KEY: begin
							if (!hnd_held) begin
								nx_status = pqdk_pkg::ST_BAD_HANDLE;
							end else if (|c_inc) begin
								nx_status = pqdk_pkg::ST_KEY_INCREASE;
							end else begin
								// Pull the entry out now and put it back next cycle.
								cell_op  = pqdk_pkg::CELL_REMOVE;
								ld_out   = 1'b0;
								go_place = 1'b1;
								nx_count = count_q - 1'b1;
							end
						end
						pqdk_pkg::CMD_DELETE_ENTRY: begin
							if (!hnd_held) begin
								nx_status = pqdk_pkg::ST_BAD_HANDLE;
							end else begin
								cell_op  = pqdk_pkg::CELL_REMOVE;
								slot_clr = 1'b1;
								nx_hnd   = in_hnd;
								nx_key   = sel_key;
								nx_pay   = sel_pay;
								nx_count = count_q - 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			PLACE: begin
				cell_op  = pqdk_pkg::CELL_INSERT;
				new_key  = pend_key_q;
				new_pay  = pend_pay_q;
				new_hnd  = pend_hnd_q;
				ld_out   = 1'b1;
				nx_hnd   = pend_hnd_q;
				nx_key   = pend_key_q;
				nx_pay   = pend_pay_q;
				nx_count = count_q + 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
			count_q     <= '0;
			slot_q      <= '0;
		end else begin
			count_q <= nx_count;
			if (slot_set) slot_q[slot_idx] <= 1'b1;
			if (slot_clr) slot_q[slot_idx] <= 1'b0;
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE:    if (go_place) state_q <= PLACE;
				PLACE:   state_q <= IDLE;
			endcase
		end
	end

	// Result and pending-entry payload registers.
	always_ff @(posedge clk) begin
		if (ld_out) begin
			out_status_q <= nx_status;
			out_hnd_q    <= nx_hnd;
			out_key_q    <= nx_key;
			out_pay_q    <= nx_pay;
		end
		if (go_place) begin
			pend_key_q <= in_key;
			pend_pay_q <= sel_pay;
			pend_hnd_q <= in_hnd;
		end
	end

	// The count register already holds the value after the command that loaded
	// the result, since nothing else changes it before the beat leaves.
	logic out_empty;
	assign out_empty = (count_q == '0);

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = OUT_W'({count_q, out_empty, out_pay_q, out_key_q, out_hnd_q});

`include "priority_queue_decrease_key_assert.svh"

	// While a decreased entry is out of the chain its slot stays taken, so the
	// slot map and the count agree only between commands.
	`PQDK_ASSERT(a_count_bound, count_q <= CW'(CAPACITY))
	`PQDK_ASSERT_IMPL(a_count_slots, state_q == IDLE, $countones(slot_q) == 32'(count_q))
	`PQDK_ASSERT(a_head_valid, c_valid[0] == (count_q != '0))
	`PQDK_ASSERT_IMPL(a_place_after_accept, state_q == PLACE, $past(in_fire))

endmodule

>>> sv/pqdk_cell.sv
// One cell of the sorted chain: holds one entry and trades it with its neighbors.
// Depends on pqdk_pkg for the cell operation codes.
module pqdk_cell #(
	parameter int KEY_BITS     = 32,
	parameter int PAYLOAD_BITS = 16,
	parameter int HANDLE_BITS  = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pqdk_pkg::cell_op_t         op,
	input  logic signed [KEY_BITS-1:0] new_key,
	input  logic [PAYLOAD_BITS-1:0]    new_pay,
	input  logic [HANDLE_BITS-1:0]     new_hnd,
	input  logic [HANDLE_BITS-1:0]     match_hnd,
	input  logic signed [KEY_BITS-1:0] prev_key,
	input  logic [PAYLOAD_BITS-1:0]    prev_pay,
	input  logic [HANDLE_BITS-1:0]     prev_hnd,
	input  logic                       prev_valid,
	input  logic                       prev_le,
	input  logic                       prev_after,
	input  logic signed [KEY_BITS-1:0] next_key,
	input  logic [PAYLOAD_BITS-1:0]    next_pay,
	input  logic [HANDLE_BITS-1:0]     next_hnd,
	input  logic                       next_valid,
	output logic signed [KEY_BITS-1:0] key,
	output logic [PAYLOAD_BITS-1:0]    pay,
	output logic [HANDLE_BITS-1:0]     hnd,
	output logic                       valid,
	output logic                       le,
	output logic                       match,
	output logic                       after,
	output logic                       inc
);

	logic signed [KEY_BITS-1:0] key_q;
	logic [PAYLOAD_BITS-1:0]    pay_q;
	logic [HANDLE_BITS-1:0]     hnd_q;
	logic                       valid_q;

	// The new entry goes behind every cell whose key is less than or equal to it.
	assign le    = valid_q && (key_q <= new_key);
	assign match = valid_q && (hnd_q == match_hnd);
	assign after = prev_after | match;
	assign inc   = match && (new_key > key_q);

	assign key   = key_q;
	assign pay   = pay_q;
	assign hnd   = hnd_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			unique case (op)
				pqdk_pkg::CELL_INSERT: valid_q <= valid_q | prev_valid;
				pqdk_pkg::CELL_REMOVE: if (after) valid_q <= next_valid;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			pqdk_pkg::CELL_INSERT: begin
				if (!le) begin
					if (prev_le) begin
						key_q <= new_key;
						pay_q <= new_pay;
						hnd_q <= new_hnd;
					end else begin
						key_q <= prev_key;
						pay_q <= prev_pay;
						hnd_q <= prev_hnd;
					end
				end
			end
			pqdk_pkg::CELL_REMOVE: begin
				if (after) begin
					key_q <= next_key;
					pay_q <= next_pay;
					hnd_q <= next_hnd;
				end
			end
			default: ;
		endcase
	end

endmodule
